@@ sv/pipo_pkg.sv @@
// Shared types, constants and round functions of the PIPO-64 pipeline.
package pipo_pkg;

   localparam int NumCells   = 17;
   localparam int RoundWidth = 5;

   localparam logic [RoundWidth-1:0] Rounds128 = RoundWidth'(13);
   localparam logic [RoundWidth-1:0] Rounds256 = RoundWidth'(17);
   localparam logic [RoundWidth-1:0] LastCell  = RoundWidth'(NumCells);

   localparam logic [2:0] CsrMode   = 3'd0;
   localparam logic [2:0] CsrChunk0 = 3'd1;
   localparam logic [2:0] CsrChunk1 = 3'd2;
   localparam logic [2:0] CsrChunk2 = 3'd3;
   localparam logic [2:0] CsrChunk3 = 3'd4;

   localparam logic CmdEncrypt = 1'b0;
   localparam logic CmdDecrypt = 1'b1;

   localparam logic [2:0] RotFwd [8] = '{3'd0, 3'd7, 3'd4, 3'd3, 3'd6, 3'd5, 3'd1, 3'd2};
   localparam logic [2:0] RotInv [8] = '{3'd0, 3'd1, 3'd4, 3'd5, 3'd2, 3'd3, 3'd7, 3'd6};

   typedef logic [7:0][7:0] plane_type;

   typedef struct packed {
      logic      valid;
      logic      command;
      plane_type data;
   } stage_type;

   typedef struct packed {
      logic             mode;
      logic [3:0][63:0] chunk;
   } key_type;

   function automatic logic [7:0] rotl8(input logic [7:0] x, input logic [2:0] n);
      logic [15:0] t;
      t = {x, x} << n;
      return t[15:8];
   endfunction

   function automatic plane_type p_layer(input plane_type x, input logic inv);
      plane_type y;
      for (int k = 0; k < 8; k++) begin
         y[k] = rotl8(x[k], inv ? RotInv[k] : RotFwd[k]);
      end
      return y;
   endfunction

   function automatic plane_type s_layer(input plane_type xi);
      plane_type x;
      logic [7:0] a, b, c;
      x = xi;
      x[5] ^= x[7] & x[6];
      x[4] ^= x[3] & x[5];
      x[7] ^= x[4];
      x[6] ^= x[3];
      x[3] ^= x[4] | x[5];
      x[5] ^= x[7];
      x[4] ^= x[5] & x[6];
      x[2] ^= x[1] & x[0];
      x[0] ^= x[2] | x[1];
      x[1] ^= x[2] | x[0];
      x[2] = ~x[2];
      x[7] ^= x[1];
      x[3] ^= x[2];
      x[4] ^= x[0];
      a = x[7];
      b = x[3];
      c = x[4];
      x[6] ^= a & x[5];
      a ^= x[6];
      x[6] ^= c | b;
      b ^= x[5];
      x[5] ^= x[6] | c;
      c ^= b & a;
      x[2] ^= a;
      a = x[1] ^ c;
      x[1] = x[0] ^ b;
      x[0] = x[7];
      x[7] = a;
      b = x[3];
      x[3] = x[6];
      x[6] = b;
      c = x[4];
      x[4] = x[5];
      x[5] = c;
      return x;
   endfunction

   function automatic plane_type inv_s_layer(input plane_type xi);
      plane_type x;
      logic [7:0] a, b, c;
      x = xi;
      a = x[7];
      x[7] = x[0];
      x[0] = x[1];
      x[1] = a;
      a = x[7];
      b = x[6];
      c = x[5];
      x[4] ^= x[3] | c;
      x[3] ^= c | b;
      b ^= x[4];
      a ^= x[3];
      c ^= b & a;
      x[3] ^= x[4] & x[7];
      x[0] ^= b;
      x[1] ^= c;
      x[2] ^= a;
      a = x[3];
      x[3] = x[6];
      x[6] = a;
      a = x[5];
      x[5] = x[4];
      x[4] = a;
      x[7] ^= x[1];
      x[3] ^= x[2];
      x[4] ^= x[0];
      x[4] ^= x[5] & x[6];
      x[5] ^= x[7];
      x[3] ^= x[4] | x[5];
      x[6] ^= x[3];
      x[7] ^= x[4];
      x[4] ^= x[3] & x[5];
      x[5] ^= x[7] & x[6];
      x[2] = ~x[2];
      x[1] ^= x[2] | x[0];
      x[0] ^= x[2] | x[1];
      x[2] ^= x[1] & x[0];
      return x;
   endfunction

   function automatic logic [63:0] round_subkey(input key_type key,
                                                 input logic [RoundWidth-1:0] i);
      logic [1:0] idx;
      idx = key.mode ? i[1:0] : {1'b0, i[0]};
      return key.chunk[idx] ^ {{(64-RoundWidth){1'b0}}, i};
   endfunction

endpackage

@@ sv/pipo_cell.sv @@
// Registered PIPO round cell: a full encrypt or decrypt round, or a pass-through.
module pipo_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [pipo_pkg::RoundWidth-1:0]   cell_index,
   input  pipo_pkg::key_type                 key,
   input  pipo_pkg::stage_type               stage_in,
   output pipo_pkg::stage_type               stage_out
);
   import pipo_pkg::*;

   logic                  valid_ff;
   logic                  command_ff;
   plane_type             data_ff;
   plane_type             data_in;
   logic [RoundWidth-1:0] round;
   logic [RoundWidth-1:0] rounds;
   logic                  active;
   plane_type             rk;

   always_comb begin
      round   = (stage_in.command == CmdDecrypt) ? RoundWidth'(LastCell + 1'b1 - cell_index)
                                                 : cell_index;
      rounds  = key.mode ? Rounds256 : Rounds128;
      active  = (round <= rounds);
      rk      = round_subkey(key, round);
      data_in = stage_in.data;
      if (active) begin
         if (stage_in.command == CmdEncrypt) begin
            data_in = p_layer(s_layer(stage_in.data), 1'b0) ^ rk;
         end else begin
            data_in = inv_s_layer(p_layer(stage_in.data ^ rk, 1'b1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stage_in.valid;
      end
      command_ff <= stage_in.command;
      data_ff    <= data_in;
   end

   assign stage_out = '{valid: valid_ff, command: command_ff, data: data_ff};

endmodule

@@ sv/pipo_block_cipher.sv @@
// PIPO-64 block cipher: a chain of seventeen round cells, one block per cycle.
//
//   channel   ports                                    handshake
//   -------   --------------------------------------   ------------------------
//   request   start, busy, req_command, req_block_in   start && !busy
//   response  rsp_valid, rsp_block_out                 rsp_valid, one cycle
//   csr       csr_valid, csr_ready, csr_index, csr_data csr_valid && csr_ready
//
// A block is accepted every cycle; busy stays low. Its result passes through one
// input register, one cell per round and one output register.
// With a 128-bit key the four unused cells pass the word through unchanged.
// Reset clears the pipeline valid bits and all key registers.
// The receiver cannot stall: rsp_valid is a one-cycle strobe.
module pipo_block_cipher (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic [63:0] req_block_in,
   output logic        rsp_valid,
   output logic [63:0] rsp_block_out,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   import pipo_pkg::*;

   key_type   key_ff;
   key_type   key_in;
   stage_type chain [NumCells+1];
   logic      head_valid_ff;
   logic      head_command_ff;
   plane_type head_data_ff;
   logic      rsp_valid_ff;
   plane_type rsp_data_ff;
   plane_type rsp_data_in;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_comb begin
      key_in = key_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CsrMode:   key_in.mode     = csr_data[0];
            CsrChunk0: key_in.chunk[0] = csr_data;
            CsrChunk1: key_in.chunk[1] = csr_data;
            CsrChunk2: key_in.chunk[2] = csr_data;
            CsrChunk3: key_in.chunk[3] = csr_data;
            default:   key_in = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff        <= '0;
         head_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         key_ff        <= key_in;
         head_valid_ff <= start && !busy;
         rsp_valid_ff  <= chain[NumCells].valid;
      end
      head_command_ff <= req_command;
      head_data_ff    <= (req_command == CmdEncrypt) ? (req_block_in ^ key_ff.chunk[0])
                                                     : req_block_in;
      rsp_data_ff     <= rsp_data_in;
   end

   assign chain[0] = '{valid: head_valid_ff, command: head_command_ff, data: head_data_ff};

   for (genvar k = 0; k < NumCells; k++) begin : g_cell
      pipo_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (RoundWidth'(k + 1)),
         .key        (key_ff),
         .stage_in   (chain[k]),
         .stage_out  (chain[k+1])
      );
   end

   assign rsp_data_in = (chain[NumCells].command == CmdDecrypt)
                        ? (chain[NumCells].data ^ key_ff.chunk[0])
                        : chain[NumCells].data;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_block_out = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##19 rsp_valid)
      else $error("accepted block produced no response after 19 cycles");

   a_latency_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 19))
      else $error("response without a block accepted 19 cycles earlier");

   a_chain_tail: assert property (@(posedge clock) disable iff (reset)
      chain[NumCells].valid |=> rsp_valid)
      else $error("last cell output not forwarded to response");
`endif

endmodule
